[hw/rtl/sld_pkg.sv]
package sld_pkg;

  localparam logic [7:0] SyncFirst  = 8'hE0;
  localparam logic [7:0] SyncSecond = 8'h55;
  localparam logic [7:0] SyncThird  = 8'hAA;
  localparam logic [7:0] LimitReset = 8'd128;

  localparam int unsigned TrailerBytes = 4;
  localparam logic [7:0]  TrailerLast  = 8'(TrailerBytes - 1);

  localparam int unsigned PaddrWidth = 3;
  localparam int unsigned PdataWidth = 32;

  localparam logic RegLengthLimit = 1'b0;

  localparam logic KindPayload  = 1'b0;
  localparam logic KindFrameEnd = 1'b1;

  typedef enum logic [2:0] {
    PhHunt  = 3'd0,
    PhGot1  = 3'd1,
    PhGot2  = 3'd2,
    PhLen   = 3'd3,
    PhData  = 3'd4,
    PhTrail = 3'd5
  } sld_phase_e;

  typedef struct packed {
    logic        result_kind;
    logic [7:0]  payload_byte;
    logic [7:0]  byte_index;
    logic [7:0]  frame_length;
    logic [31:0] trailer_word;
  } sld_result_t;

endpackage

[hw/rtl/sld_stream_if.sv]
interface sld_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

interface sld_out_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic [7:0]  payload_byte;
  logic [7:0]  byte_index;
  logic [7:0]  frame_length;
  logic [31:0] trailer_word;

  modport source (
    output valid, output result_kind, output payload_byte, output byte_index,
    output frame_length, output trailer_word, input ready
  );
  modport sink (
    input valid, input result_kind, input payload_byte, input byte_index,
    input frame_length, input trailer_word, output ready
  );
endinterface

[hw/rtl/sld_cfg_regs.sv]
module sld_cfg_regs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [sld_pkg::PaddrWidth-1:0]  paddr,
  input  logic [sld_pkg::PdataWidth-1:0]  pwdata,
  output logic [sld_pkg::PdataWidth-1:0]  prdata,
  output logic                            pready,
  output logic [7:0]                      length_limit_o
);
  import sld_pkg::*;

  logic       sel_limit;
  logic       wr_en;
  logic [7:0] limit_q;
  logic [7:0] limit_d;

  assign sel_limit = (paddr[PaddrWidth-1] == RegLengthLimit);
  assign wr_en     = psel && penable && pwrite;
  assign pready    = 1'b1;

  always_comb begin
    limit_d = limit_q;
    if (wr_en && sel_limit) begin
      limit_d = pwdata[7:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LimitReset;
    end else begin
      limit_q <= limit_d;
    end
  end

  always_comb begin
    prdata = '0;
    if (sel_limit) begin
      prdata = {{(PdataWidth-8){1'b0}}, limit_q};
    end
  end

  assign length_limit_o = limit_q;

endmodule

[hw/rtl/sld_parser.sv]
module sld_parser (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 accept_i,
  input  logic [7:0]           in_byte_i,
  input  logic [7:0]           length_limit_i,
  output logic                 push_o,
  output sld_pkg::sld_result_t result_o
);
  import sld_pkg::*;

  sld_phase_e  phase_q, phase_d;
  logic [7:0]  len_q, len_d;
  logic [7:0]  cnt_q, cnt_d;
  logic [23:0] trail_q, trail_d;
  sld_phase_e  restart;
  logic [8:0]  cnt_inc;

  assign restart = (in_byte_i == SyncFirst) ? PhGot1 : PhHunt;
  assign cnt_inc = {1'b0, cnt_q} + 9'd1;

  always_comb begin
    phase_d = phase_q;
    if (accept_i) begin
      case (phase_q)
        PhGot1:  phase_d = (in_byte_i == SyncSecond) ? PhGot2 : restart;
        PhGot2:  phase_d = (in_byte_i == SyncThird) ? PhLen : restart;
        PhLen: begin
          if (in_byte_i >= length_limit_i) begin
            phase_d = restart;
          end else if (in_byte_i == 8'd0) begin
            phase_d = PhTrail;
          end else begin
            phase_d = PhData;
          end
        end
        PhData: begin
          if (cnt_inc >= {1'b0, len_q}) begin
            phase_d = PhTrail;
          end
        end
        PhTrail: begin
          if (cnt_q >= TrailerLast) begin
            phase_d = PhHunt;
          end
        end
        default: phase_d = restart;
      endcase
    end
  end

  always_comb begin
    len_d    = len_q;
    cnt_d    = cnt_q;
    trail_d  = trail_q;
    push_o   = 1'b0;
    result_o = '0;
    result_o.frame_length = len_q;
    if (accept_i) begin
      case (phase_q)
        PhLen: begin
          if (in_byte_i < length_limit_i) begin
            len_d   = in_byte_i;
            cnt_d   = '0;
            trail_d = '0;
          end
        end
        PhData: begin
          push_o                = 1'b1;
          result_o.result_kind  = KindPayload;
          result_o.payload_byte = in_byte_i;
          result_o.byte_index   = cnt_q;
          cnt_d                 = cnt_inc[7:0];
          if (cnt_inc >= {1'b0, len_q}) begin
            cnt_d   = '0;
            trail_d = '0;
          end
        end
        PhTrail: begin
          if (cnt_q < TrailerLast) begin
            trail_d = {trail_q[15:0], in_byte_i};
            cnt_d   = cnt_inc[7:0];
          end else begin
            push_o                = 1'b1;
            result_o.result_kind  = KindFrameEnd;
            result_o.trailer_word = {trail_q, in_byte_i};
            cnt_d                 = '0;
            trail_d               = '0;
          end
        end
        default: begin
          len_d = len_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhHunt;
      len_q   <= '0;
      cnt_q   <= '0;
      trail_q <= '0;
    end else begin
      phase_q <= phase_d;
      len_q   <= len_d;
      cnt_q   <= cnt_d;
      trail_q <= trail_d;
    end
  end

endmodule

[hw/rtl/sld_out_buf.sv]
module sld_out_buf (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  sld_pkg::sld_result_t data_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output sld_pkg::sld_result_t out_data_o
);
  import sld_pkg::*;

  logic        out_valid_q, out_valid_d;
  logic        skid_valid_q, skid_valid_d;
  sld_result_t out_q, out_d;
  sld_result_t skid_q, skid_d;
  logic        pop;

  assign pop        = out_valid_q && out_ready_i;
  assign in_ready_o = !skid_valid_q;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (skid_valid_q) begin
      if (pop) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end
    end else if (!out_valid_q || pop) begin
      out_valid_d = push_i;
      if (push_i) begin
        out_d = data_i;
      end
    end else if (push_i) begin
      skid_d       = data_i;
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

[hw/rtl/sync_length_frame_deframer.sv]
// Frame deframer for a byte stream of the form E0 55 AA, length, payload, four trailer
// bytes. It takes one byte per cycle unless its one-entry skid register is full; the
// phase machine updates its state in the same cycle a byte is accepted and each result
// is registered into the output register, or into the skid register while the output
// is stalled, so bytes keep flowing while a result waits. Each payload byte yields one
// result carrying its index, and the last trailer byte yields a frame-end result with the
// length and the trailer as a big-endian word; header and length bytes yield nothing. A
// length byte at or above the length_limit register (address 0, reset 128) drops the
// header and is rescanned as a possible header start. The trailer is passed on unchecked.
module sync_length_frame_deframer (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  sld_in_if.sink                          in_i,
  sld_out_if.source                       out_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [sld_pkg::PaddrWidth-1:0]  paddr,
  input  logic [sld_pkg::PdataWidth-1:0]  pwdata,
  output logic [sld_pkg::PdataWidth-1:0]  prdata,
  output logic                            pready
);
  import sld_pkg::*;

  logic        accept;
  logic        push;
  logic [7:0]  length_limit;
  sld_result_t result;
  sld_result_t out_data;

  assign accept = in_i.valid && in_i.ready;

  sld_cfg_regs u_cfg (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .length_limit_o (length_limit)
  );

  sld_parser u_parser (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .in_byte_i      (in_i.in_byte),
    .length_limit_i (length_limit),
    .push_o         (push),
    .result_o       (result)
  );

  sld_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .data_i      (result),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_data_o  (out_data)
  );

  assign out_o.result_kind  = out_data.result_kind;
  assign out_o.payload_byte = out_data.payload_byte;
  assign out_o.byte_index   = out_data.byte_index;
  assign out_o.frame_length = out_data.frame_length;
  assign out_o.trailer_word = out_data.trailer_word;

endmodule

[hw/rtl/sld_checker.sv]
module sld_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic        result_kind_i,
  input logic [7:0]  payload_byte_i,
  input logic [7:0]  byte_index_i,
  input logic [7:0]  frame_length_i,
  input logic [31:0] trailer_word_i
);
  import sld_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(result_kind_i)
      && $stable(payload_byte_i) && $stable(byte_index_i)
      && $stable(frame_length_i) && $stable(trailer_word_i))
    else $error("result changed while stalled");

  a_end_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (result_kind_i == KindFrameEnd)
      |-> (payload_byte_i == 8'd0) && (byte_index_i == 8'd0))
    else $error("frame-end result carries payload fields");

  a_payload_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (result_kind_i == KindPayload)
      |-> (trailer_word_i == 32'd0) && (byte_index_i < frame_length_i))
    else $error("payload result index or trailer out of range");

endmodule

bind sync_length_frame_deframer sld_checker u_sld_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .result_kind_i  (out_o.result_kind),
  .payload_byte_i (out_o.payload_byte),
  .byte_index_i   (out_o.byte_index),
  .frame_length_i (out_o.frame_length),
  .trailer_word_i (out_o.trailer_word)
);
